>>> hdl/wifd_pkg.sv
// Package for weighted_image_feature_distance.
// Types and constants shared by controller and datapath, and the controller's state encoding.
package wifd_pkg;

  localparam int NumGroups   = 3;
  localparam int MaxGroupLen = 64;
  localparam int FeatWidth   = 16;
  localparam int LenWidth    = 7;
  localparam int ScaleWidth  = 18;
  localparam int SumWidth    = 23;
  localparam int SqWidth     = 38;
  localparam int TotWidth    = 34;
  localparam int RadWidth    = 46;  // square_sum << 8
  localparam int RootWidth   = 23;
  localparam int QuoWidth    = 17;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDatWidth = 18;

  localparam logic [CfgIdxWidth-1:0] RegLen0  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegLen1  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegLen2  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegMask  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegScl0  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegScl1  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegScl2  = 3'd6;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accumulate;
    logic clr_group;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic use_div;
    logic zero_term;
    logic mul;
    logic add;
    logic load_out;
    logic clr_total;
  } cmd_t;

  typedef struct packed {
    logic first_sum_zero;
  } stat_t;

endpackage

>>> hdl/weighted_image_feature_distance.sv
// Top level of weighted_image_feature_distance.
// Holds config registers and joins wifd_ctrl and wifd_datapath; uses wifd_pkg.
//
// One word (feature_a, feature_b) is taken per cycle inside a group. At the end
// of each group the input stalls while the term is formed by the serial divider
// (intersection) or the serial square root (Euclidean), followed by the scale
// multiply and total add; after the last group the output register is loaded.
// The result register lets the next frame start while a result waits.
module weighted_image_feature_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // feature_a[15:0], feature_b[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // distance[31:0], zero_sum_flag[32], saturated_flag[33]
  input  logic                               cfg_we,
  input  logic [wifd_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [wifd_pkg::CfgDatWidth-1:0]   cfg_data
);

  logic [wifd_pkg::LenWidth-1:0]   len_r [wifd_pkg::NumGroups];
  logic [wifd_pkg::ScaleWidth-1:0] scl_r [wifd_pkg::NumGroups];
  logic [2:0] mask_r;
  wifd_pkg::cmd_t  cmd;
  wifd_pkg::stat_t stat;
  logic [1:0]  group;
  logic        zflag, sat;
  logic [31:0] distance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0] <= 7'd3;
      len_r[1] <= 7'd48;
      len_r[2] <= 7'd15;
      mask_r   <= '0;
      scl_r[0] <= 18'd21845;
      scl_r[1] <= 18'd364;
      scl_r[2] <= 18'd21845;
    end else if (cfg_we) begin
      case (cfg_index)
        wifd_pkg::RegLen0: len_r[0] <= cfg_data[wifd_pkg::LenWidth-1:0];
        wifd_pkg::RegLen1: len_r[1] <= cfg_data[wifd_pkg::LenWidth-1:0];
        wifd_pkg::RegLen2: len_r[2] <= cfg_data[wifd_pkg::LenWidth-1:0];
        wifd_pkg::RegMask: mask_r   <= cfg_data[2:0];
        wifd_pkg::RegScl0: scl_r[0] <= cfg_data;
        wifd_pkg::RegScl1: scl_r[1] <= cfg_data;
        wifd_pkg::RegScl2: scl_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  wifd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid & in_tready),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .len       (len_r[group]),
    .isect     (mask_r[group]),
    .stat      (stat),
    .cmd       (cmd),
    .group     (group),
    .zero_flag (zflag)
  );

  wifd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .feat_a   (in_tdata[15:0]),
    .feat_b   (in_tdata[31:16]),
    .scale    (scl_r[group]),
    .distance (distance),
    .sat      (sat)
  );

  assign out_tdata = {6'd0, sat, zflag, distance};

endmodule

>>> hdl/wifd_datapath.sv
// Datapath for weighted_image_feature_distance: sums, serial divider,
// serial square root, scale multiply and total. Uses wifd_pkg.
module wifd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wifd_pkg::cmd_t                      cmd,
  output wifd_pkg::stat_t                     stat,
  input  logic [wifd_pkg::FeatWidth-1:0]      feat_a,
  input  logic [wifd_pkg::FeatWidth-1:0]      feat_b,
  input  logic [wifd_pkg::ScaleWidth-1:0]     scale,
  output logic [31:0]                         distance,
  output logic                                sat
);

  logic [wifd_pkg::SumWidth-1:0]  min_sum_r, first_sum_r;
  logic [wifd_pkg::SqWidth-1:0]   sq_sum_r;
  logic [wifd_pkg::TotWidth-1:0]  total_r;
  logic [wifd_pkg::SumWidth+16:0] rem_r;    // divider partial remainder / dividend
  logic [wifd_pkg::QuoWidth-1:0]  quo_r;
  logic [wifd_pkg::RadWidth-1:0]  rad_r;
  logic [wifd_pkg::RadWidth-1:0]  root_r;
  logic [wifd_pkg::RadWidth-1:0]  bit_r;
  logic [wifd_pkg::RootWidth-1:0] term_r;
  logic [wifd_pkg::RootWidth+wifd_pkg::ScaleWidth-1:0] prod_r;
  logic [wifd_pkg::FeatWidth-1:0] diff, mn;
  logic [wifd_pkg::SumWidth:0]    trial;
  logic [wifd_pkg::RadWidth-1:0]  rb;
  logic [wifd_pkg::TotWidth:0]    tsum;
  logic [wifd_pkg::TotWidth-1:0]  wgt;

  assign diff = (feat_a >= feat_b) ? feat_a - feat_b : feat_b - feat_a;
  assign mn   = (feat_a >= feat_b) ? feat_b : feat_a;
  assign trial = rem_r[wifd_pkg::SumWidth+16:16] - {1'b0, first_sum_r};
  assign rb   = root_r + bit_r;
  assign wgt  = wifd_pkg::TotWidth'(prod_r >> 16);
  assign tsum = {1'b0, total_r} + {1'b0, wgt};
  assign stat.first_sum_zero = (first_sum_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sum_r   <= '0;
      first_sum_r <= '0;
      sq_sum_r    <= '0;
      total_r     <= '0;
    end else begin
      if (cmd.accumulate) begin
        min_sum_r   <= min_sum_r + wifd_pkg::SumWidth'(mn);
        first_sum_r <= first_sum_r + wifd_pkg::SumWidth'(feat_a);
        sq_sum_r    <= sq_sum_r + wifd_pkg::SqWidth'({16'd0, diff} * {16'd0, diff});
      end
      if (cmd.clr_group) begin
        min_sum_r   <= '0;
        first_sum_r <= '0;
        sq_sum_r    <= '0;
      end
      if (cmd.add) begin
        total_r <= tsum[wifd_pkg::TotWidth] ? '1 : tsum[wifd_pkg::TotWidth-1:0];
      end
      if (cmd.clr_total) begin
        total_r <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per cycle (17 steps)
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= {1'b0, min_sum_r, 16'd0};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[wifd_pkg::SumWidth]) begin
        rem_r <= {trial[wifd_pkg::SumWidth-1:0], rem_r[15:0], 1'b0};
        quo_r <= {quo_r[wifd_pkg::QuoWidth-2:0], 1'b1};
      end else begin
        rem_r <= rem_r << 1;
        quo_r <= {quo_r[wifd_pkg::QuoWidth-2:0], 1'b0};
      end
    end
  end

  // bitwise square root, two radicand bits per cycle (23 steps)
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r  <= {sq_sum_r, 8'd0};
      root_r <= '0;
      bit_r  <= wifd_pkg::RadWidth'(1) << (wifd_pkg::RadWidth - 2);
    end else if (cmd.sqrt_step) begin
      if (rad_r >= rb) begin
        rad_r  <= rad_r - rb;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (cmd.zero_term)
        term_r <= '0;
      else if (cmd.use_div)
        term_r <= wifd_pkg::RootWidth'(18'h10000 - {1'b0, quo_r});
      else
        term_r <= root_r[wifd_pkg::RootWidth-1:0];
    end
    prod_r <= term_r * scale;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sat      <= (total_r[wifd_pkg::TotWidth-1:32] != '0);
      distance <= (total_r[wifd_pkg::TotWidth-1:32] != '0) ? '1 : total_r[31:0];
    end
  end

endmodule

>>> hdl/wifd_ctrl.sv
// Controller for weighted_image_feature_distance: element and group counts,
// sequencing of divide, root, multiply and output. Uses wifd_pkg.
module wifd_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  output logic                              in_ready,
  input  logic                              out_ready,
  output logic                              out_valid,
  input  logic [wifd_pkg::LenWidth-1:0]     len,
  input  logic                              isect,
  input  wifd_pkg::stat_t                   stat,
  output wifd_pkg::cmd_t                    cmd,
  output logic [1:0]                        group,
  output logic                              zero_flag
);

  wifd_pkg::state_t state_r, state_nxt;
  logic [wifd_pkg::LenWidth-1:0] pos_r, pos_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic zf_r, zf_nxt, ov_r, ov_nxt, fz_r, fz_nxt;
  logic [wifd_pkg::LenWidth-1:0] eff;

  assign group     = grp_r;
  assign zero_flag = fz_r;
  assign out_valid = ov_r;

  always_comb begin
    eff = (len == '0) ? wifd_pkg::LenWidth'(1) :
          (len > wifd_pkg::LenWidth'(wifd_pkg::MaxGroupLen)) ?
          wifd_pkg::LenWidth'(wifd_pkg::MaxGroupLen) : len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wifd_pkg::ST_ACC;
      pos_r   <= '0;
      grp_r   <= '0;
      cnt_r   <= '0;
      zf_r    <= 1'b0;
      ov_r    <= 1'b0;
      fz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      grp_r   <= grp_nxt;
      cnt_r   <= cnt_nxt;
      zf_r    <= zf_nxt;
      ov_r    <= ov_nxt;
      fz_r    <= fz_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    grp_nxt   = grp_r;
    cnt_nxt   = cnt_r;
    zf_nxt    = zf_r;
    fz_nxt    = fz_r;
    ov_nxt    = ov_r & ~out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      wifd_pkg::ST_ACC: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.accumulate = 1'b1;
          pos_nxt = pos_r + 1'b1;
          if (pos_r + 1'b1 >= eff) begin
            pos_nxt = '0;
            if (isect) begin
              state_nxt = wifd_pkg::ST_DIV;
            end else begin
              state_nxt = wifd_pkg::ST_SQRT;
            end
          end
        end
      end
      wifd_pkg::ST_DIV: begin
        if (cnt_r == 5'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 5'd1;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 5'd17) begin
            cnt_nxt = '0;
            state_nxt = wifd_pkg::ST_MUL;
          end
        end
      end
      wifd_pkg::ST_SQRT: begin
        if (cnt_r == 5'd0) begin
          cmd.sqrt_start = 1'b1;
          cnt_nxt = 5'd1;
        end else begin
          cmd.sqrt_step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 5'd23) begin
            cnt_nxt = '0;
            state_nxt = wifd_pkg::ST_MUL;
          end
        end
      end
      wifd_pkg::ST_MUL: begin
        // term load, then product register
        cmd.mul       = (cnt_r == 5'd0);
        cmd.use_div   = isect;
        cmd.zero_term = isect & stat.first_sum_zero;
        if (cnt_r == 5'd0) begin
          if (isect && stat.first_sum_zero) zf_nxt = 1'b1;
          cnt_nxt = 5'd1;
        end else if (cnt_r == 5'd1) begin
          cnt_nxt = 5'd2;
        end else begin
          cnt_nxt = '0;
          cmd.clr_group = 1'b1;
          state_nxt = wifd_pkg::ST_ADD;
        end
      end
      wifd_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        if (grp_r == 2'(wifd_pkg::NumGroups - 1)) begin
          grp_nxt = '0;
          state_nxt = wifd_pkg::ST_OUT;
        end else begin
          grp_nxt = grp_r + 1'b1;
          state_nxt = wifd_pkg::ST_ACC;
        end
      end
      wifd_pkg::ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.load_out  = 1'b1;
          cmd.clr_total = 1'b1;
          ov_nxt    = 1'b1;
          fz_nxt    = zf_r;
          zf_nxt    = 1'b0;
          state_nxt = wifd_pkg::ST_ACC;
        end
      end
      default: state_nxt = wifd_pkg::ST_ACC;
    endcase
  end

endmodule

>>> tb/tb_weighted_image_feature_distance.sv
// Testbench for weighted_image_feature_distance: streams feature pairs, predicts each
// frame's weighted distance in fixed point and checks every result word.
// Depends on wifd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_weighted_image_feature_distance;

  localparam int  CycleLimit = 1500000;
  localparam int  DrainCycles = 80;

  typedef struct packed {
    logic [31:0] distance;
    logic        zero_sum;
    logic        saturated;
  } dist_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [wifd_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [wifd_pkg::CfgDatWidth-1:0] cfg_data;

  // predictor copy of configuration and running state
  logic [wifd_pkg::LenWidth-1:0]   len_reg [wifd_pkg::NumGroups];
  logic [wifd_pkg::NumGroups-1:0]  isect_mask;
  logic [wifd_pkg::ScaleWidth-1:0] scale_reg [wifd_pkg::NumGroups];
  int unsigned                     elem_pos;
  int unsigned                     grp;
  logic [wifd_pkg::SumWidth-1:0]   min_acc;
  logic [wifd_pkg::SumWidth-1:0]   a_acc;
  logic [wifd_pkg::SqWidth-1:0]    sq_acc;
  logic [wifd_pkg::TotWidth-1:0]   total_acc;
  logic                            zero_seen;

  dist_result_t expected_q[$];
  int unsigned  errors;
  int unsigned  cycles;
  bit           send_idle;
  bit           recv_idle;
  bit           long_hold;

  weighted_image_feature_distance i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned eff_len(int unsigned g);
    int unsigned n;
    n = len_reg[g];
    if (n == 0) n = 1;
    if (n > wifd_pkg::MaxGroupLen) n = wifd_pkg::MaxGroupLen;
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 24; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  task automatic accumulate_pair(logic [15:0] a, logic [15:0] b);
    longint unsigned d;
    longint unsigned term;
    longint unsigned weighted;
    longint unsigned tmax;
    dist_result_t res;
    tmax = (64'd1 << wifd_pkg::TotWidth) - 1;
    d = (a >= b) ? a - b : b - a;
    min_acc += (a >= b) ? b : a;
    a_acc += a;
    sq_acc += d * d;
    elem_pos++;
    if (elem_pos < eff_len(grp)) return;
    if (isect_mask[grp]) begin
      if (a_acc == 0) begin
        term = 0;
        zero_seen = 1'b1;
      end else begin
        term = 65536 - ((64'(min_acc) << 16) / 64'(a_acc));
      end
    end else begin
      term = int_sqrt(64'(sq_acc) << 8);
    end
    weighted = (term * scale_reg[grp]) >> 16;
    if (weighted > tmax - total_acc) total_acc = tmax;
    else total_acc += weighted;
    min_acc = '0;
    a_acc = '0;
    sq_acc = '0;
    elem_pos = 0;
    grp++;
    if (grp < wifd_pkg::NumGroups) return;
    res.saturated = total_acc > 34'hFFFF_FFFF;
    res.distance = res.saturated ? 32'hFFFF_FFFF : total_acc[31:0];
    res.zero_sum = zero_seen;
    expected_q.push_back(res);
    grp = 0;
    total_acc = '0;
    zero_seen = 1'b0;
  endtask

  task automatic report(string what, logic [33:0] got, logic [33:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", out_tdata[33:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.distance) report("distance", out_tdata[31:0], want.distance);
        if (out_tdata[32] !== want.zero_sum) report("zero_sum_flag", out_tdata[32], want.zero_sum);
        if (out_tdata[33] !== want.saturated)
          report("saturated_flag", out_tdata[33], want.saturated);
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [15:0] a, logic [15:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    accumulate_pair(a, b);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic set_config(int l0, int l1, int l2, int mask, int s0, int s1, int s2);
    int vals[7];
    vals = '{l0, l1, l2, mask, s0, s1, s2};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= wifd_pkg::CfgIdxWidth'(i);
      cfg_data  <= wifd_pkg::CfgDatWidth'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (int g = 0; g < wifd_pkg::NumGroups; g++) begin
      len_reg[g]   = wifd_pkg::LenWidth'(vals[g]);
      scale_reg[g] = wifd_pkg::ScaleWidth'(vals[wifd_pkg::RegScl0 + g]);
    end
    isect_mask = wifd_pkg::NumGroups'(vals[wifd_pkg::RegMask]);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_feature(int kind);
    case (kind)
      0: return 16'(0);
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int kind);
    int unsigned n;
    logic [15:0] a;
    n = eff_len(0) + eff_len(1) + eff_len(2);
    repeat (n) begin
      a = pick_feature(kind);
      if (kind == 4) send_word(a, a);
      else send_word(a, pick_feature(kind));
    end
  endtask

  task automatic random_config();
    int l[3];
    int s[3];
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(0, 9))
        0: l[g] = wifd_pkg::MaxGroupLen;
        1: l[g] = $urandom_range(0, 127);
        default: l[g] = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 5))
        0: s[g] = 0;
        1: s[g] = 18'h3FFFF;
        default: s[g] = $urandom_range(0, 18'h3FFFF);
      endcase
    end
    set_config(l[0], l[1], l[2], $urandom_range(0, 7), s[0], s[1], s[2]);
  endtask

  task automatic test_reset_config();
    send_frame(3);
    wait_idle();
  endtask

  task automatic test_extremes();
    // intersection everywhere, zero first sum and full-scale values
    set_config(1, 2, 1, 7, 18'h3FFFF, 18'h3FFFF, 0);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h1234, 16'h0000);
    send_word(16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000);
    wait_idle();
    // Euclidean everywhere, lengths below and above range
    set_config(0, 127, 1, 0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_frame(1);
    wait_idle();
    set_config(1, 1, 1, 5, 18'h10000, 1, 18'h3FFFF);
    send_word(16'hAAAA, 16'h5555);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hFFFF, 16'h0001);
    wait_idle();
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      random_config();
      repeat ($urandom_range(1, 6)) begin
        send_frame($urandom_range(0, 7));
        sent += eff_len(0) + eff_len(1) + eff_len(2);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    set_config(1, 1, 1, 2, 18'h3FFFF, 500, 21845);
    long_hold = 1'b1;
    repeat (4) send_frame(3);
    wait_idle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cycles     = 0;
    errors     = 0;
    send_idle  = 1'b0;
    recv_idle  = 1'b0;
    long_hold  = 1'b0;
    len_reg    = '{7'd3, 7'd48, 7'd15};
    scale_reg  = '{18'd21845, 18'd364, 18'd21845};
    isect_mask = '0;
    elem_pos   = 0;
    grp        = 0;
    min_acc    = '0;
    a_acc      = '0;
    sq_acc     = '0;
    total_acc  = '0;
    zero_seen  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_extremes();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_random(1200);
    test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(400);

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/wifd_pkg.sv
hdl/wifd_datapath.sv
hdl/wifd_ctrl.sv
hdl/weighted_image_feature_distance.sv
tb/tb_weighted_image_feature_distance.sv
